[hw/rtl/assert_macros.svh]
//------------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[hw/rtl/ipd_pkg.sv]
//------------------------------------------------------------------------------
// ipd_pkg
// types and constants of the length-prefixed frame demultiplexer
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

	localparam int LEN_WIDTH_DEF     = 16;
	localparam int MAX_LEN_CHARS_DEF = 15;

	typedef enum logic [1:0] {
		ROUTE_CMD     = 2'd0,
		ROUTE_PAYLOAD = 2'd1,
		ROUTE_DROP    = 2'd2
	} route_t;

	// "+IPD" with the oldest byte highest, ',' completes the pattern
	localparam logic [31:0] PATTERN_HEAD = 32'h2B49_5044;
	localparam logic [7:0]  PATTERN_TAIL = 8'h2C;
	localparam logic [7:0]  LEN_END      = 8'h3A;
	localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
	localparam logic [7:0]  DIGIT_NINE   = 8'h39;

endpackage

`default_nettype wire

[hw/rtl/ipd_frame_demux.sv]
// the result beat is registered and valid in the cycle after its input beat is accepted
// throughput: one beat per cycle, the result register refills while it drains
// the input stalls only while the result register is full and stalled
// reset: asynchronous, active low, clears routing state, the byte window and
// the length and payload counters, and empties the result register
//------------------------------------------------------------------------------
// ipd_frame_demux
// splits a modem byte stream into command-response bytes, dropped length
// header bytes and length-delimited payload bytes
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ipd_frame_demux #(
	parameter int LEN_WIDTH     = ipd_pkg::LEN_WIDTH_DEF,
	parameter int MAX_LEN_CHARS = ipd_pkg::MAX_LEN_CHARS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           byte_valid,
	output logic                byte_stall,
	input  wire logic [7:0]     rx_byte,
	output logic                res_valid,
	input  wire logic           res_stall,
	output ipd_pkg::route_t     route,
	output logic [7:0]          out_byte,
	output logic                payload_last
);

	import ipd_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_LENGTH  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	localparam logic [LEN_WIDTH-1:0] LEN_MAX   = {LEN_WIDTH{1'b1}};
	localparam logic [3:0]           CHARS_MAX = 4'(MAX_LEN_CHARS);

	mode_t                mode_q, mode_d;
	logic [31:0]          recent_q, recent_d;
	logic [LEN_WIDTH-1:0] accum_q, accum_d;
	logic [3:0]           chars_q, chars_d;
	logic                 ended_q, ended_d;
	logic [LEN_WIDTH-1:0] left_q, left_d;

	route_t               route_d;
	logic                 last_d;
	logic                 byte_fire;
	logic                 is_digit;
	logic [LEN_WIDTH+3:0] mac;
	logic [LEN_WIDTH-1:0] left_dec;

	assign byte_stall = res_valid & res_stall;
	assign byte_fire  = byte_valid & ~byte_stall;

	assign is_digit = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
	// acc * 10 + digit, saturated below
	assign mac = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
		+ (LEN_WIDTH+4)'(rx_byte - DIGIT_ZERO);
	assign left_dec = (left_q != '0) ? left_q - LEN_WIDTH'(1) : left_q;

	always_comb begin
		mode_d   = mode_q;
		recent_d = recent_q;
		accum_d  = accum_q;
		chars_d  = chars_q;
		ended_d  = ended_q;
		left_d   = left_q;
		route_d  = ROUTE_CMD;
		last_d   = 1'b0;
		case (mode_q)
			MODE_LENGTH: begin
				route_d = ROUTE_DROP;
				if (rx_byte == LEN_END) begin
					if (accum_q == '0) begin
						mode_d = MODE_NORMAL;
					end else begin
						left_d = accum_q;
						mode_d = MODE_PAYLOAD;
					end
				end else if (chars_q < CHARS_MAX) begin
					chars_d = chars_q + 4'd1;
					if (!ended_q && is_digit) begin
						accum_d = (mac[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) ? LEN_MAX
							: mac[LEN_WIDTH-1:0];
					end else begin
						ended_d = 1'b1;
					end
				end
			end
			MODE_PAYLOAD: begin
				route_d = ROUTE_PAYLOAD;
				left_d  = left_dec;
				if (left_dec == '0) begin
					last_d = 1'b1;
					mode_d = MODE_NORMAL;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (recent_q == PATTERN_HEAD && rx_byte == PATTERN_TAIL) begin
					mode_d   = MODE_LENGTH;
					recent_d = '0;
					accum_d  = '0;
					chars_d  = '0;
					ended_d  = 1'b0;
				end else begin
					recent_d = {recent_q[23:0], rx_byte};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			recent_q  <= '0;
			accum_q   <= '0;
			chars_q   <= '0;
			ended_q   <= 1'b0;
			left_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			if (byte_fire) begin
				mode_q   <= mode_d;
				recent_q <= recent_d;
				accum_q  <= accum_d;
				chars_q  <= chars_d;
				ended_q  <= ended_d;
				left_q   <= left_d;
			end
			if (byte_fire) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (byte_fire) begin
			route        <= route_d;
			out_byte     <= rx_byte;
			payload_last <= last_d;
		end
	end

	`ASSERT_CLK(a_last_is_payload, clk, arst_n,
		res_valid && payload_last |-> route == ROUTE_PAYLOAD, "last flag outside payload")
	`ASSERT_CLK(a_payload_left, clk, arst_n,
		mode_q == MODE_PAYLOAD |-> left_q != '0, "payload mode with no bytes left")
	`ASSERT_CLK(a_length_drops, clk, arst_n,
		byte_fire && mode_q == MODE_LENGTH |=> res_valid && route == ROUTE_DROP && !payload_last,
		"length text beat not dropped")
	`ASSERT_CLK(a_payload_route, clk, arst_n,
		byte_fire && mode_q == MODE_PAYLOAD |=> res_valid && route == ROUTE_PAYLOAD,
		"payload beat misrouted")

endmodule

`default_nettype wire
